// File: hdl/prc_pkg.sv
// Package for the polygon rectangle clipper: payload structs, status codes,
// window edge indices and sequencer states. No dependencies.
package prc_pkg;

    localparam int COORD_BITS = 32;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vert_x;
        logic signed [COORD_BITS-1:0] vert_y;
        logic                         final_vertex;
    } prc_in_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic                         end_of_run;
        logic [1:0]                   status;
    } prc_out_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_BAD      = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [1:0] REG_TOP    = 2'd0;
    localparam logic [1:0] REG_LEFT   = 2'd1;
    localparam logic [1:0] REG_BOTTOM = 2'd2;
    localparam logic [1:0] REG_RIGHT  = 2'd3;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CHECK,
        S_PASS_START,
        S_PRIME,
        S_FETCH,
        S_EVAL,
        S_DIV_WAIT,
        S_PUSH_X,
        S_PUSH_E,
        S_PASS_END,
        S_EMIT_RD,
        S_EMIT,
        S_FLAG
    } prc_state_t;

endpackage

// File: hdl/prc_muldiv.sv
// Iterative signed (a*b)/d with truncation toward zero, one quotient bit
// per cycle after a registered product. Depends on nothing but its ports.
module prc_muldiv #(
    parameter int W = 33
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    input  logic signed [W-1:0] d,
    output logic                done,
    output logic signed [W-1:0] q
);
    localparam int PW = 2 * W;
    localparam int CW = $clog2(PW + 1);

    logic [W-1:0]  ua, ub, ud_next;
    logic [W-1:0]  ud_reg;
    logic [PW-1:0] prod_reg, prod_next;
    logic [W:0]    rem_reg, rem_next, rem_sh;
    logic [W-1:0]  quo_reg, quo_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          mul_reg, mul_next;
    logic          done_reg, done_next;
    logic [W-1:0]  ua_reg, ub_reg, ua_next, ub_next;

    assign ua = a[W-1] ? W'(-a) : W'(a);
    assign ub = b[W-1] ? W'(-b) : W'(b);
    assign ud_next = d[W-1] ? W'(-d) : W'(d);
    assign rem_sh = {rem_reg[W-1:0], prod_reg[PW-1]};

    always_comb begin
        prod_next = prod_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        mul_next  = mul_reg;
        done_next = 1'b0;
        ua_next   = ua_reg;
        ub_next   = ub_reg;
        if (start) begin
            ua_next   = ua;
            ub_next   = ub;
            neg_next  = (a[W-1] ^ b[W-1]) ^ d[W-1];
            mul_next  = 1'b1;
            busy_next = 1'b1;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = CW'(PW);
        end else if (mul_reg) begin
            prod_next = PW'(ua_reg) * PW'(ub_reg);
            mul_next  = 1'b0;
        end else if (busy_reg) begin
            prod_next = {prod_reg[PW-2:0], 1'b0};
            if (rem_sh >= {1'b0, ud_reg}) begin
                rem_next = rem_sh - {1'b0, ud_reg};
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            mul_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            mul_reg  <= mul_next;
            done_reg <= done_next;
        end
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        ua_reg   <= ua_next;
        ub_reg   <= ub_next;
        if (start) ud_reg <= ud_next;
    end

    assign done = done_reg;
    assign q    = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
endmodule

// File: hdl/polygon_rectangle_clipper.sv
// Top level of the polygon rectangle clipper: vertex stores, pass sequencer
// and result register. Uses prc_pkg and prc_muldiv.
//
// Usage: vertices arrive one beat each on s_ (valid/ready); the beat with
// final_vertex set closes the polygon. Window edges are written through the
// cfg_ channel (index 0 top, 1 left, 2 bottom, 3 right) while idle.
// A non-final vertex is taken whenever s_valid is high in the load state.
// After the final vertex the block drops s_ready, checks the window and then
// runs four clipping passes over two vertex memories; each intersection found
// on the way goes through the single shared bit-serial divider.
// Results then leave on m_, one vertex per beat, each going through a memory
// read and then the output register, the last one with end_of_run set.
// A bad window, short input or empty pass gives a single flagged beat.
// If the receiver stalls, the output register holds and the sequencer waits.
// Reset clears the window registers, counts and overflow flag; the vertex
// memories are not cleared and need no clearing pass.
module polygon_rectangle_clipper #(
    parameter int MAX_IN_VERTS  = 16,
    parameter int MAX_BUF_VERTS = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  prc_pkg::prc_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output prc_pkg::prc_out_t m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [prc_pkg::COORD_BITS-1:0] cfg_data
);
    import prc_pkg::*;

    localparam int AW = $clog2(MAX_BUF_VERTS);
    localparam int NW = $clog2(MAX_BUF_VERTS + 1);
    localparam int CB = COORD_BITS;
    localparam int DW = CB + 1;

    logic signed [CB-1:0] mem_a_x [MAX_BUF_VERTS];
    logic signed [CB-1:0] mem_a_y [MAX_BUF_VERTS];
    logic signed [CB-1:0] mem_b_x [MAX_BUF_VERTS];
    logic signed [CB-1:0] mem_b_y [MAX_BUF_VERTS];

    logic signed [CB-1:0] top_reg, left_reg, bottom_reg, right_reg;
    prc_state_t state_reg, state_next;
    logic [NW-1:0] cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic          ovf_reg, ovf_next;
    logic [1:0]    pass_reg, pass_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic [AW-1:0] rd_addr;
    logic signed [CB-1:0] rd_x, rd_y;
    logic signed [CB-1:0] sk_reg, so_reg, sk_next, so_next;
    logic signed [CB-1:0] ek_reg, eo_reg, ek_next, eo_next;
    logic          keep_e_reg, keep_e_next;
    logic [1:0]    flag_reg, flag_next;
    prc_out_t      out_reg, out_next;
    logic          ovalid_reg, ovalid_next;

    // Pass 0/2 read store a and write b; passes 1/3 the other way.
    logic          src_a;
    logic          ax_y, keep_gt;
    logic signed [CB-1:0] bound;
    logic [NW-1:0] ns, nd;
    logic          e_in, s_in, s_out, e_on;
    logic          wr_en;
    logic signed [CB-1:0] wr_k, wr_o;
    logic          div_start, div_done;
    logic signed [DW-1:0] div_q;
    logic signed [CB-1:0] ix_o;
    logic          out_free;

    assign src_a   = ~pass_reg[0];
    assign ax_y    = pass_reg[1];
    assign keep_gt = ~pass_reg[0];
    always_comb begin
        case (pass_reg)
            2'd0:    bound = left_reg;
            2'd1:    bound = right_reg;
            2'd2:    bound = bottom_reg;
            default: bound = top_reg;
        endcase
    end
    assign ns = src_a ? cnt_a_reg : cnt_b_reg;
    assign nd = src_a ? cnt_b_reg : cnt_a_reg;

    assign e_in  = keep_gt ? (ek_reg > bound) : (ek_reg < bound);
    assign s_in  = keep_gt ? (sk_reg > bound) : (sk_reg < bound);
    assign s_out = keep_gt ? (sk_reg < bound) : (sk_reg > bound);
    assign e_on  = (ek_reg == bound);

    assign out_free = ~ovalid_reg | m_ready;
    assign s_ready  = (state_reg == S_LOAD);
    assign cfg_ready = (state_reg == S_LOAD);

    prc_muldiv #(.W(DW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .a       (DW'(eo_reg) - DW'(so_reg)),
        .b       (DW'(bound) - DW'(sk_reg)),
        .d       (DW'(ek_reg) - DW'(sk_reg)),
        .done    (div_done),
        .q       (div_q)
    );
    assign ix_o = CB'(DW'(so_reg) + div_q);

    // The priming fetch reads the last source vertex as the start point.
    always_comb begin
        rd_addr = AW'(idx_reg);
        if (state_reg == S_FETCH && idx_reg == ns) rd_addr = AW'(ns - 1'b1);
    end

    always_comb begin
        state_next  = state_reg;
        cnt_a_next  = cnt_a_reg;
        cnt_b_next  = cnt_b_reg;
        ovf_next    = ovf_reg;
        pass_next   = pass_reg;
        idx_next    = idx_reg;
        sk_next     = sk_reg;
        so_next     = so_reg;
        ek_next     = ek_reg;
        eo_next     = eo_reg;
        keep_e_next = keep_e_reg;
        flag_next   = flag_reg;
        div_start   = 1'b0;
        case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    if (32'(cnt_a_reg) < 32'(MAX_IN_VERTS)
                        && 32'(cnt_a_reg) < 32'(MAX_BUF_VERTS)) begin
                        cnt_a_next = cnt_a_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_data.final_vertex) state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                pass_next = 2'd0;
                if (top_reg <= bottom_reg || right_reg <= left_reg
                    || cnt_a_reg < NW'(3)) begin
                    flag_next  = ST_BAD;
                    state_next = S_FLAG;
                end else begin
                    state_next = S_PASS_START;
                end
            end
            S_PASS_START: begin
                idx_next = '0;
                if (src_a) cnt_b_next = '0;
                else       cnt_a_next = '0;
                state_next = S_PRIME;
            end
            S_PRIME: state_next = S_FETCH;
            S_FETCH: begin
                // The address is presented here; its data is valid in S_EVAL.
                state_next = S_EVAL;
            end
            S_EVAL: begin
                ek_next = ax_y ? rd_y : rd_x;
                eo_next = ax_y ? rd_x : rd_y;
                if (idx_reg == ns) begin
                    // Priming read: this is the start vertex.
                    sk_next  = ax_y ? rd_y : rd_x;
                    so_next  = ax_y ? rd_x : rd_y;
                    idx_next = '0;
                    state_next = S_FETCH;
                end else begin
                    state_next = S_PUSH_X;
                end
            end
            S_PUSH_X: begin
                keep_e_next = e_in || (!(e_in || !e_on && s_in) && e_on);
                if ((e_in && s_out) || (!e_in && !e_on && s_in)) begin
                    div_start  = 1'b1;
                    state_next = S_DIV_WAIT;
                end else begin
                    state_next = S_PUSH_E;
                end
            end
            S_DIV_WAIT: begin
                if (div_done) state_next = S_PUSH_E;
            end
            S_PUSH_E: begin
                sk_next  = ek_reg;
                so_next  = eo_reg;
                idx_next = idx_reg + 1'b1;
                if (idx_reg + 1'b1 == ns) state_next = S_PASS_END;
                else                       state_next = S_FETCH;
            end
            S_PASS_END: begin
                if (nd == '0) begin
                    flag_next  = ST_EMPTY;
                    state_next = S_FLAG;
                end else if (pass_reg == 2'd3) begin
                    idx_next   = '0;
                    state_next = S_EMIT_RD;
                end else begin
                    pass_next  = pass_reg + 1'b1;
                    state_next = S_PASS_START;
                end
            end
            S_EMIT_RD: state_next = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg + 1'b1 == cnt_a_reg) begin
                        cnt_a_next = '0;
                        cnt_b_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end else begin
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_FLAG: begin
                if (out_free) begin
                    cnt_a_next = '0;
                    cnt_b_next = '0;
                    ovf_next   = 1'b0;
                    state_next = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
        // The priming read uses idx == ns as its marker.
        if (state_reg == S_PRIME) idx_next = ns;
    end

    // Destination writes: intersection on the divider's done or skip, then E.
    always_comb begin
        wr_en = 1'b0;
        wr_k  = bound;
        wr_o  = ix_o;
        if (state_reg == S_DIV_WAIT && div_done) begin
            wr_en = 1'b1;
        end else if (state_reg == S_PUSH_E && keep_e_reg) begin
            wr_en = 1'b1;
            wr_k  = ek_reg;
            wr_o  = eo_reg;
        end
    end

    logic [NW-1:0] nd_after_x;

    always_comb begin
        nd_after_x = nd;
        if (wr_en) begin
            if (32'(nd) < 32'(MAX_BUF_VERTS)) nd_after_x = nd + 1'b1;
        end
    end
    logic wr_ok;
    assign wr_ok = wr_en && (32'(nd) < 32'(MAX_BUF_VERTS));

    always_comb begin
        out_next    = out_reg;
        ovalid_next = ovalid_reg & ~m_ready;
        if (state_reg == S_EMIT && out_free) begin
            ovalid_next        = 1'b1;
            out_next.out_x     = rd_x;
            out_next.out_y     = rd_y;
            out_next.end_of_run = (idx_reg + 1'b1 == cnt_a_reg);
            out_next.status    = ovf_reg ? ST_OVERFLOW : ST_OK;
        end else if (state_reg == S_FLAG && out_free) begin
            ovalid_next         = 1'b1;
            out_next.out_x      = '0;
            out_next.out_y      = '0;
            out_next.end_of_run = 1'b1;
            out_next.status     = flag_reg;
        end
    end

    logic [NW-1:0] cnt_a_fin, cnt_b_fin;
    logic          ovf_fin;
    always_comb begin
        cnt_a_fin = cnt_a_next;
        cnt_b_fin = cnt_b_next;
        ovf_fin   = ovf_next;
        if (wr_en) begin
            if (wr_ok) begin
                if (src_a) cnt_b_fin = nd_after_x;
                else       cnt_a_fin = nd_after_x;
            end else begin
                ovf_fin = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_LOAD;
            cnt_a_reg  <= '0;
            cnt_b_reg  <= '0;
            ovf_reg    <= 1'b0;
            pass_reg   <= 2'd0;
            ovalid_reg <= 1'b0;
            top_reg    <= '0;
            left_reg   <= '0;
            bottom_reg <= '0;
            right_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            cnt_a_reg  <= cnt_a_fin;
            cnt_b_reg  <= cnt_b_fin;
            ovf_reg    <= ovf_fin;
            pass_reg   <= pass_next;
            ovalid_reg <= ovalid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TOP:    top_reg    <= CB'(signed'(cfg_data));
                    REG_LEFT:   left_reg   <= CB'(signed'(cfg_data));
                    REG_BOTTOM: bottom_reg <= CB'(signed'(cfg_data));
                    REG_RIGHT:  right_reg  <= CB'(signed'(cfg_data));
                    default: ;
                endcase
            end
        end
        idx_reg    <= idx_next;
        sk_reg     <= sk_next;
        so_reg     <= so_next;
        ek_reg     <= ek_next;
        eo_reg     <= eo_next;
        keep_e_reg <= keep_e_next;
        flag_reg   <= flag_next;
        out_reg    <= out_next;
    end

    // Vertex memories: one write port, one registered read port each.
    logic signed [CB-1:0] ra_x_reg, ra_y_reg, rb_x_reg, rb_y_reg;
    logic signed [CB-1:0] wx, wy;
    logic load_wr;
    assign load_wr = (state_reg == S_LOAD) && s_valid
                     && 32'(cnt_a_reg) < 32'(MAX_IN_VERTS)
                     && 32'(cnt_a_reg) < 32'(MAX_BUF_VERTS);
    assign wx = ax_y ? wr_o : wr_k;
    assign wy = ax_y ? wr_k : wr_o;

    always_ff @(posedge aclk) begin
        if (load_wr) begin
            mem_a_x[AW'(cnt_a_reg)] <= CB'(s_data.vert_x);
            mem_a_y[AW'(cnt_a_reg)] <= CB'(s_data.vert_y);
        end else if (wr_ok && !src_a) begin
            mem_a_x[AW'(nd)] <= wx;
            mem_a_y[AW'(nd)] <= wy;
        end
        ra_x_reg <= mem_a_x[rd_addr];
        ra_y_reg <= mem_a_y[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_ok && src_a) begin
            mem_b_x[AW'(nd)] <= wx;
            mem_b_y[AW'(nd)] <= wy;
        end
        rb_x_reg <= mem_b_x[rd_addr];
        rb_y_reg <= mem_b_y[rd_addr];
    end

    // Emission always reads store a; passes read their source store.
    always_comb begin
        rd_x = (src_a || state_reg == S_EMIT) ? ra_x_reg : rb_x_reg;
        rd_y = (src_a || state_reg == S_EMIT) ? ra_y_reg : rb_y_reg;
    end

    assign m_valid = ovalid_reg;
    assign m_data  = out_reg;
endmodule
